### rtl/core/trimet_pkg.sv
// Shared widths and inter-stage record types of the triangle metrics datapath.
package trimet_pkg;

  localparam int SIDE_W     = 27;              // side length, Q.10
  localparam int SUM_W      = SIDE_W + 1;      // sum or difference of two sides
  localparam int PER_W      = SIDE_W + 2;      // perimeter
  localparam int AREA_W     = 43;              // area field
  localparam int OUT_W      = 27;              // heights, medians, bisectors
  localparam int PROD_W     = PER_W + SUM_W;   // perimeter times a side difference
  localparam int DPROD_W    = 2 * SUM_W;       // product of two side differences
  localparam int SQ_W       = 2 * SIDE_W;      // product of two sides
  localparam int MQ_W       = SQ_W + 2;        // radicand of a median
  localparam int ROOT_W     = 57;              // widest square root result
  localparam int RAD_W      = 2 * ROOT_W;      // radicand width of the root units
  localparam int AREA_SHIFT = 12;              // root of Heron product to Q.10 area

  // Output of the front stages: checks, sums and all narrow products.
  typedef struct packed {
    logic                ok;
    logic [PER_W-1:0]    per;
    logic [SIDE_W-1:0]   a;
    logic [SIDE_W-1:0]   b;
    logic [SIDE_W-1:0]   c;
    logic [SUM_W-1:0]    s_bc;
    logic [SUM_W-1:0]    s_ac;
    logic [SUM_W-1:0]    s_ab;
    logic [PROD_W-1:0]   pda;
    logic [PROD_W-1:0]   pdb;
    logic [PROD_W-1:0]   pdc;
    logic [DPROD_W-1:0]  dbc;
    logic [SQ_W-1:0]     bc;
    logic [SQ_W-1:0]     ac;
    logic [SQ_W-1:0]     ab;
    logic [MQ_W-1:0]     qa;
    logic [MQ_W-1:0]     qb;
    logic [MQ_W-1:0]     qc;
  } front_t;

  // Side data riding along the Heron product multiplier.
  typedef struct packed {
    logic              ok;
    logic [PER_W-1:0]  per;
    logic [SIDE_W-1:0] a;
    logic [SIDE_W-1:0] b;
    logic [SIDE_W-1:0] c;
    logic [MQ_W-1:0]   qa;
    logic [MQ_W-1:0]   qb;
    logic [MQ_W-1:0]   qc;
  } mtag_t;

  // Side data riding along the Heron square root.
  typedef struct packed {
    logic              ok;
    logic [PER_W-1:0]  per;
    logic [SIDE_W-1:0] a;
    logic [SIDE_W-1:0] b;
    logic [SIDE_W-1:0] c;
  } rtag_t;

  // Side data riding along the first height divider.
  typedef struct packed {
    logic              ok;
    logic [PER_W-1:0]  per;
    logic [AREA_W-1:0] area;
    logic [OUT_W-1:0]  ma;
    logic [OUT_W-1:0]  mb;
    logic [OUT_W-1:0]  mc;
  } htag_t;

endpackage

### rtl/core/trimet_front.sv
// Front stages: triangle check, sums, narrow products and median radicands.
module trimet_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_vld,
  input  logic [trimet_pkg::SIDE_W-1:0]        a,
  input  logic [trimet_pkg::SIDE_W-1:0]        b,
  input  logic [trimet_pkg::SIDE_W-1:0]        c,
  output logic                                 out_vld,
  output trimet_pkg::front_t                   res
);
  localparam int QX_W = trimet_pkg::MQ_W + 1;

  // Stage 1 registers.
  logic                              vld1, ok1;
  logic [trimet_pkg::SIDE_W-1:0]     a1, b1, c1;
  logic [trimet_pkg::PER_W-1:0]      per1;
  logic [trimet_pkg::SUM_W-1:0]      da1, db1, dc1, sbc1, sac1, sab1;
  // Stage 2 registers.
  logic                              vld2, ok2;
  logic [trimet_pkg::SIDE_W-1:0]     a2, b2, c2;
  logic [trimet_pkg::PER_W-1:0]      per2;
  logic [trimet_pkg::SUM_W-1:0]      sbc2, sac2, sab2;
  logic [trimet_pkg::PROD_W-1:0]     pda2, pdb2, pdc2;
  logic [trimet_pkg::DPROD_W-1:0]    dbc2;
  logic [trimet_pkg::SQ_W-1:0]       bc2, ac2, ab2, sqa2, sqb2, sqc2;

  logic [trimet_pkg::SUM_W-1:0]      sbc, sac, sab;
  logic [QX_W-1:0]                   qa_w, qb_w, qc_w;

  always_comb begin
    sbc  = {1'b0, b} + {1'b0, c};
    sac  = {1'b0, a} + {1'b0, c};
    sab  = {1'b0, a} + {1'b0, b};
    qa_w = ((QX_W'(sqb2) + QX_W'(sqc2)) << 1) - QX_W'(sqa2);
    qb_w = ((QX_W'(sqa2) + QX_W'(sqc2)) << 1) - QX_W'(sqb2);
    qc_w = ((QX_W'(sqa2) + QX_W'(sqb2)) << 1) - QX_W'(sqc2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      vld2    <= vld1;
      out_vld <= vld2;
    end
    if (en) begin
      ok1  <= (sab > {1'b0, c}) && (sac > {1'b0, b}) && (sbc > {1'b0, a});
      a1   <= a;
      b1   <= b;
      c1   <= c;
      per1 <= {1'b0, sbc} + trimet_pkg::PER_W'(a);
      da1  <= sbc - {1'b0, a};
      db1  <= sac - {1'b0, b};
      dc1  <= sab - {1'b0, c};
      sbc1 <= sbc;
      sac1 <= sac;
      sab1 <= sab;

      ok2  <= ok1;
      a2   <= a1;
      b2   <= b1;
      c2   <= c1;
      per2 <= per1;
      sbc2 <= sbc1;
      sac2 <= sac1;
      sab2 <= sab1;
      pda2 <= trimet_pkg::PROD_W'(per1) * trimet_pkg::PROD_W'(da1);
      pdb2 <= trimet_pkg::PROD_W'(per1) * trimet_pkg::PROD_W'(db1);
      pdc2 <= trimet_pkg::PROD_W'(per1) * trimet_pkg::PROD_W'(dc1);
      dbc2 <= trimet_pkg::DPROD_W'(db1) * trimet_pkg::DPROD_W'(dc1);
      bc2  <= trimet_pkg::SQ_W'(b1) * trimet_pkg::SQ_W'(c1);
      ac2  <= trimet_pkg::SQ_W'(a1) * trimet_pkg::SQ_W'(c1);
      ab2  <= trimet_pkg::SQ_W'(a1) * trimet_pkg::SQ_W'(b1);
      sqa2 <= trimet_pkg::SQ_W'(a1) * trimet_pkg::SQ_W'(a1);
      sqb2 <= trimet_pkg::SQ_W'(b1) * trimet_pkg::SQ_W'(b1);
      sqc2 <= trimet_pkg::SQ_W'(c1) * trimet_pkg::SQ_W'(c1);

      res.ok   <= ok2;
      res.per  <= per2;
      res.a    <= a2;
      res.b    <= b2;
      res.c    <= c2;
      res.s_bc <= sbc2;
      res.s_ac <= sac2;
      res.s_ab <= sab2;
      res.pda  <= pda2;
      res.pdb  <= pdb2;
      res.pdc  <= pdc2;
      res.dbc  <= dbc2;
      res.bc   <= bc2;
      res.ac   <= ac2;
      res.ab   <= ab2;
      res.qa   <= qa_w[trimet_pkg::MQ_W-1:0];
      res.qb   <= qb_w[trimet_pkg::MQ_W-1:0];
      res.qc   <= qc_w[trimet_pkg::MQ_W-1:0];
    end
  end

endmodule

### rtl/core/trimet_wmul.sv
// Wide multiplier built from four half-width partial products over two stages.
module trimet_wmul #(
  parameter int AW    = 57,
  parameter int BW    = 56,
  parameter int TAG_W = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  logic [AW-1:0]      x,
  input  logic [BW-1:0]      y,
  input  logic [TAG_W-1:0]   in_tag,
  output logic               out_vld,
  output logic [AW+BW-1:0]   prod,
  output logic [TAG_W-1:0]   out_tag
);
  localparam int AL   = (AW + 1) / 2;
  localparam int AH   = AW - AL;
  localparam int BL   = (BW + 1) / 2;
  localparam int BH   = BW - BL;
  localparam int PW   = AW + BW;
  localparam int LL_W = AL + BL;
  localparam int LH_W = AL + BH;
  localparam int HL_W = AH + BL;
  localparam int HH_W = AH + BH;

  logic               vld1;
  logic [TAG_W-1:0]   tag1;
  logic [LL_W-1:0]    p_ll;
  logic [LH_W-1:0]    p_lh;
  logic [HL_W-1:0]    p_hl;
  logic [HH_W-1:0]    p_hh;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      out_vld <= vld1;
    end
    if (en) begin
      p_ll    <= LL_W'(x[AL-1:0]) * LL_W'(y[BL-1:0]);
      p_lh    <= LH_W'(x[AL-1:0]) * LH_W'(y[BW-1:BL]);
      p_hl    <= HL_W'(x[AW-1:AL]) * HL_W'(y[BL-1:0]);
      p_hh    <= HH_W'(x[AW-1:AL]) * HH_W'(y[BW-1:BL]);
      tag1    <= in_tag;
      prod    <= (PW'(p_hh) << (AL + BL)) + (PW'(p_hl) << AL) + (PW'(p_lh) << BL)
                 + PW'(p_ll);
      out_tag <= tag1;
    end
  end

endmodule

### rtl/core/trimet_sqrt.sv
// Pipelined integer floor square root, one result bit per stage.
module trimet_sqrt #(
  parameter int RW    = 57,
  parameter int TAG_W = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  logic [2*RW-1:0]    rad,
  input  logic [TAG_W-1:0]   in_tag,
  output logic               out_vld,
  output logic [RW-1:0]      root,
  output logic [TAG_W-1:0]   out_tag
);
  logic              vld [RW];
  logic [RW-1:0]     rt  [RW];
  logic [RW+1:0]     rm  [RW];
  logic [2*RW-1:0]   nb  [RW];
  logic [TAG_W-1:0]  tg  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic              s_vld;
    logic [RW-1:0]     s_rt;
    logic [RW+1:0]     s_rm;
    logic [2*RW-1:0]   s_nb;
    logic [TAG_W-1:0]  s_tg;
    logic [RW+3:0]     part, trial, diff;
    logic              take;

    if (k == 0) begin : g_src
      assign s_vld = in_vld;
      assign s_rt  = '0;
      assign s_rm  = '0;
      assign s_nb  = rad;
      assign s_tg  = in_tag;
    end else begin : g_src
      assign s_vld = vld[k-1];
      assign s_rt  = rt[k-1];
      assign s_rm  = rm[k-1];
      assign s_nb  = nb[k-1];
      assign s_tg  = tg[k-1];
    end

    // Bring down the next two radicand bits and try a 1 in the next root bit.
    always_comb begin
      part  = {s_rm, s_nb[2*RW-1 -: 2]};
      trial = {2'b00, s_rt, 2'b01};
      diff  = part - trial;
      take  = (part >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= s_vld;
      end
      if (en) begin
        rt[k] <= {s_rt[RW-2:0], take};
        rm[k] <= take ? diff[RW+1:0] : part[RW+1:0];
        nb[k] <= {s_nb[2*RW-3:0], 2'b00};
        tg[k] <= s_tg;
      end
    end
  end

  assign out_vld = vld[RW-1];
  assign root    = rt[RW-1];
  assign out_tag = tg[RW-1];

endmodule

### rtl/core/trimet_div.sv
// Pipelined restoring divider, one quotient bit per stage; needs num < den * 2**QW.
module trimet_div #(
  parameter int NW    = 57,
  parameter int DW    = 28,
  parameter int QW    = 27,
  parameter int TAG_W = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  logic [NW-1:0]      num,
  input  logic [DW-1:0]      den,
  input  logic [TAG_W-1:0]   in_tag,
  output logic               out_vld,
  output logic [QW-1:0]      quo,
  output logic [TAG_W-1:0]   out_tag
);
  logic              vld [QW];
  logic [DW-1:0]     rm  [QW];
  logic [DW-1:0]     dn  [QW];
  logic [QW-1:0]     lo  [QW];
  logic [QW-1:0]     qt  [QW];
  logic [TAG_W-1:0]  tg  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic              s_vld;
    logic [DW-1:0]     s_rm, s_dn;
    logic [QW-1:0]     s_lo, s_qt;
    logic [TAG_W-1:0]  s_tg;
    logic [DW:0]       part, diff;
    logic              take;

    if (k == 0) begin : g_src
      assign s_vld = in_vld;
      assign s_rm  = num[QW +: DW];
      assign s_dn  = den;
      assign s_lo  = num[QW-1:0];
      assign s_qt  = '0;
      assign s_tg  = in_tag;
    end else begin : g_src
      assign s_vld = vld[k-1];
      assign s_rm  = rm[k-1];
      assign s_dn  = dn[k-1];
      assign s_lo  = lo[k-1];
      assign s_qt  = qt[k-1];
      assign s_tg  = tg[k-1];
    end

    always_comb begin
      part = {s_rm, s_lo[QW-1]};
      diff = part - {1'b0, s_dn};
      take = (part >= {1'b0, s_dn});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= s_vld;
      end
      if (en) begin
        rm[k] <= take ? diff[DW-1:0] : part[DW-1:0];
        dn[k] <= s_dn;
        lo[k] <= {s_lo[QW-2:0], 1'b0};
        qt[k] <= {s_qt[QW-2:0], take};
        tg[k] <= s_tg;
      end
    end
  end

  assign out_vld = vld[QW-1];
  assign quo     = qt[QW-1];
  assign out_tag = tg[QW-1];

endmodule

### rtl/core/triangle_metrics.sv
// Top level of the triangle metrics pipeline: perimeter, area, heights, medians, bisectors.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-------------------------------------------
//   sides    | side_valid / side_ready     | side_a, side_b, side_c
//   metrics  | metric_valid / metric_ready | valid_res, perimeter, area, height_*, ...
//
// A request can enter in every cycle while the output is not stalled; each one passes
// three front stages, two multiplier stages, 57 square root stages, 27 divider stages
// and the output register. The long square roots and divisions make up most of that depth.
// Reset clears only the valid bits of the stages; data registers are not reset.
// The whole pipeline advances whenever the output register is empty or being taken,
// so a stall at the output freezes every stage in place and nothing is lost or repeated.
module triangle_metrics (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                side_valid,
  output logic                                side_ready,
  input  logic [trimet_pkg::SIDE_W-1:0]       side_a,
  input  logic [trimet_pkg::SIDE_W-1:0]       side_b,
  input  logic [trimet_pkg::SIDE_W-1:0]       side_c,
  output logic                                metric_valid,
  input  logic                                metric_ready,
  output logic                                valid_res,
  output logic [trimet_pkg::PER_W-1:0]        perimeter,
  output logic [trimet_pkg::AREA_W-1:0]       area,
  output logic [trimet_pkg::OUT_W-1:0]        height_a,
  output logic [trimet_pkg::OUT_W-1:0]        height_b,
  output logic [trimet_pkg::OUT_W-1:0]        height_c,
  output logic [trimet_pkg::OUT_W-1:0]        median_a,
  output logic [trimet_pkg::OUT_W-1:0]        median_b,
  output logic [trimet_pkg::OUT_W-1:0]        median_c,
  output logic [trimet_pkg::OUT_W-1:0]        bisector_a,
  output logic [trimet_pkg::OUT_W-1:0]        bisector_b,
  output logic [trimet_pkg::OUT_W-1:0]        bisector_c
);
  localparam int MT_W  = $bits(trimet_pkg::mtag_t);
  localparam int RT_W  = $bits(trimet_pkg::rtag_t);
  localparam int HT_W  = $bits(trimet_pkg::htag_t);
  localparam int HP_W  = trimet_pkg::PROD_W + trimet_pkg::DPROD_W;
  localparam int BP_W  = trimet_pkg::SQ_W + trimet_pkg::PROD_W;

  // One enable moves every stage; the output register is the last stage.
  logic adv;
  assign adv        = !metric_valid || metric_ready;
  assign side_ready = adv;

  // Front: check, sums, narrow products.
  logic               f_vld;
  trimet_pkg::front_t f;

  trimet_front u_front (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .in_vld (side_valid),
    .a      (side_a),
    .b      (side_b),
    .c      (side_c),
    .out_vld(f_vld),
    .res    (f)
  );

  // Wide products: the Heron product and the three bisector radicands.
  logic                    hp_vld, bpa_vld;
  logic [HP_W-1:0]         hp;
  logic [BP_W-1:0]         bpa, bpb, bpc;
  trimet_pkg::mtag_t       m_in, m_out;
  logic [trimet_pkg::SUM_W-1:0] bsa, bsb, bsc;

  always_comb begin
    m_in.ok  = f.ok;
    m_in.per = f.per;
    m_in.a   = f.a;
    m_in.b   = f.b;
    m_in.c   = f.c;
    m_in.qa  = f.qa;
    m_in.qb  = f.qb;
    m_in.qc  = f.qc;
  end

  trimet_wmul #(.AW(trimet_pkg::PROD_W), .BW(trimet_pkg::DPROD_W), .TAG_W(MT_W)) u_hmul (
    .clk(clk), .rst(rst), .en(adv), .in_vld(f_vld),
    .x(f.pda), .y(f.dbc), .in_tag(m_in),
    .out_vld(hp_vld), .prod(hp), .out_tag(m_out)
  );

  trimet_wmul #(.AW(trimet_pkg::SQ_W), .BW(trimet_pkg::PROD_W),
                .TAG_W(trimet_pkg::SUM_W)) u_bmul_a (
    .clk(clk), .rst(rst), .en(adv), .in_vld(f_vld),
    .x(f.bc), .y(f.pda), .in_tag(f.s_bc),
    .out_vld(bpa_vld), .prod(bpa), .out_tag(bsa)
  );

  trimet_wmul #(.AW(trimet_pkg::SQ_W), .BW(trimet_pkg::PROD_W),
                .TAG_W(trimet_pkg::SUM_W)) u_bmul_b (
    .clk(clk), .rst(rst), .en(adv), .in_vld(f_vld),
    .x(f.ac), .y(f.pdb), .in_tag(f.s_ac),
    .out_vld(), .prod(bpb), .out_tag(bsb)
  );

  trimet_wmul #(.AW(trimet_pkg::SQ_W), .BW(trimet_pkg::PROD_W),
                .TAG_W(trimet_pkg::SUM_W)) u_bmul_c (
    .clk(clk), .rst(rst), .en(adv), .in_vld(f_vld),
    .x(f.ab), .y(f.pdc), .in_tag(f.s_ab),
    .out_vld(), .prod(bpc), .out_tag(bsc)
  );

  // Square roots. All run the full root width so that every path has the same depth.
  logic                              hr_vld;
  logic [trimet_pkg::ROOT_W-1:0]     hroot, broot_a, broot_b, broot_c;
  logic [trimet_pkg::ROOT_W-1:0]     mroot_a, mroot_b, mroot_c;
  trimet_pkg::rtag_t                 r_in, r_out;
  logic [trimet_pkg::SUM_W-1:0]      bda, bdb, bdc;

  always_comb begin
    r_in.ok  = m_out.ok;
    r_in.per = m_out.per;
    r_in.a   = m_out.a;
    r_in.b   = m_out.b;
    r_in.c   = m_out.c;
  end

  trimet_sqrt #(.RW(trimet_pkg::ROOT_W), .TAG_W(RT_W)) u_hsqrt (
    .clk(clk), .rst(rst), .en(adv), .in_vld(hp_vld),
    .rad(trimet_pkg::RAD_W'(hp)), .in_tag(r_in),
    .out_vld(hr_vld), .root(hroot), .out_tag(r_out)
  );

  trimet_sqrt #(.RW(trimet_pkg::ROOT_W), .TAG_W(trimet_pkg::SUM_W)) u_bsqrt_a (
    .clk(clk), .rst(rst), .en(adv), .in_vld(bpa_vld),
    .rad(trimet_pkg::RAD_W'(bpa)), .in_tag(bsa),
    .out_vld(), .root(broot_a), .out_tag(bda)
  );

  trimet_sqrt #(.RW(trimet_pkg::ROOT_W), .TAG_W(trimet_pkg::SUM_W)) u_bsqrt_b (
    .clk(clk), .rst(rst), .en(adv), .in_vld(bpa_vld),
    .rad(trimet_pkg::RAD_W'(bpb)), .in_tag(bsb),
    .out_vld(), .root(broot_b), .out_tag(bdb)
  );

  trimet_sqrt #(.RW(trimet_pkg::ROOT_W), .TAG_W(trimet_pkg::SUM_W)) u_bsqrt_c (
    .clk(clk), .rst(rst), .en(adv), .in_vld(bpa_vld),
    .rad(trimet_pkg::RAD_W'(bpc)), .in_tag(bsc),
    .out_vld(), .root(broot_c), .out_tag(bdc)
  );

  trimet_sqrt #(.RW(trimet_pkg::ROOT_W), .TAG_W(1)) u_msqrt_a (
    .clk(clk), .rst(rst), .en(adv), .in_vld(hp_vld),
    .rad(trimet_pkg::RAD_W'(m_out.qa)), .in_tag(1'b0),
    .out_vld(), .root(mroot_a), .out_tag()
  );

  trimet_sqrt #(.RW(trimet_pkg::ROOT_W), .TAG_W(1)) u_msqrt_b (
    .clk(clk), .rst(rst), .en(adv), .in_vld(hp_vld),
    .rad(trimet_pkg::RAD_W'(m_out.qb)), .in_tag(1'b0),
    .out_vld(), .root(mroot_b), .out_tag()
  );

  trimet_sqrt #(.RW(trimet_pkg::ROOT_W), .TAG_W(1)) u_msqrt_c (
    .clk(clk), .rst(rst), .en(adv), .in_vld(hp_vld),
    .rad(trimet_pkg::RAD_W'(m_out.qc)), .in_tag(1'b0),
    .out_vld(), .root(mroot_c), .out_tag()
  );

  // Divisions: heights divide the Heron root by twice a side, bisectors by a side pair.
  // The finished area, perimeter and medians ride along the first height divider.
  logic                              ha_vld, hb_vld, ba_vld;
  logic [trimet_pkg::OUT_W-1:0]      q_ha, q_hb, q_hc, q_ba, q_bb, q_bc;
  trimet_pkg::htag_t                 h_in, h_out;

  always_comb begin
    h_in.ok   = r_out.ok;
    h_in.per  = r_out.per;
    h_in.area = hroot[trimet_pkg::AREA_SHIFT +: trimet_pkg::AREA_W];
    h_in.ma   = mroot_a[trimet_pkg::OUT_W:1];
    h_in.mb   = mroot_b[trimet_pkg::OUT_W:1];
    h_in.mc   = mroot_c[trimet_pkg::OUT_W:1];
  end

  trimet_div #(.NW(trimet_pkg::ROOT_W), .DW(trimet_pkg::SUM_W), .QW(trimet_pkg::OUT_W),
               .TAG_W(HT_W)) u_hdiv_a (
    .clk(clk), .rst(rst), .en(adv), .in_vld(hr_vld),
    .num(hroot), .den({r_out.a, 1'b0}), .in_tag(h_in),
    .out_vld(ha_vld), .quo(q_ha), .out_tag(h_out)
  );

  trimet_div #(.NW(trimet_pkg::ROOT_W), .DW(trimet_pkg::SUM_W), .QW(trimet_pkg::OUT_W),
               .TAG_W(1)) u_hdiv_b (
    .clk(clk), .rst(rst), .en(adv), .in_vld(hr_vld),
    .num(hroot), .den({r_out.b, 1'b0}), .in_tag(1'b0),
    .out_vld(hb_vld), .quo(q_hb), .out_tag()
  );

  trimet_div #(.NW(trimet_pkg::ROOT_W), .DW(trimet_pkg::SUM_W), .QW(trimet_pkg::OUT_W),
               .TAG_W(1)) u_hdiv_c (
    .clk(clk), .rst(rst), .en(adv), .in_vld(hr_vld),
    .num(hroot), .den({r_out.c, 1'b0}), .in_tag(1'b0),
    .out_vld(), .quo(q_hc), .out_tag()
  );

  trimet_div #(.NW(trimet_pkg::ROOT_W), .DW(trimet_pkg::SUM_W), .QW(trimet_pkg::OUT_W),
               .TAG_W(1)) u_bdiv_a (
    .clk(clk), .rst(rst), .en(adv), .in_vld(hr_vld),
    .num(broot_a), .den(bda), .in_tag(1'b0),
    .out_vld(ba_vld), .quo(q_ba), .out_tag()
  );

  trimet_div #(.NW(trimet_pkg::ROOT_W), .DW(trimet_pkg::SUM_W), .QW(trimet_pkg::OUT_W),
               .TAG_W(1)) u_bdiv_b (
    .clk(clk), .rst(rst), .en(adv), .in_vld(hr_vld),
    .num(broot_b), .den(bdb), .in_tag(1'b0),
    .out_vld(), .quo(q_bb), .out_tag()
  );

  trimet_div #(.NW(trimet_pkg::ROOT_W), .DW(trimet_pkg::SUM_W), .QW(trimet_pkg::OUT_W),
               .TAG_W(1)) u_bdiv_c (
    .clk(clk), .rst(rst), .en(adv), .in_vld(hr_vld),
    .num(broot_c), .den(bdc), .in_tag(1'b0),
    .out_vld(), .quo(q_bc), .out_tag()
  );

  // Output register. A failed triangle check forces every field to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      metric_valid <= 1'b0;
    end else if (adv) begin
      metric_valid <= ha_vld;
    end
    if (adv) begin
      valid_res  <= h_out.ok;
      perimeter  <= h_out.ok ? h_out.per  : '0;
      area       <= h_out.ok ? h_out.area : '0;
      height_a   <= h_out.ok ? q_ha       : '0;
      height_b   <= h_out.ok ? q_hb       : '0;
      height_c   <= h_out.ok ? q_hc       : '0;
      median_a   <= h_out.ok ? h_out.ma   : '0;
      median_b   <= h_out.ok ? h_out.mb   : '0;
      median_c   <= h_out.ok ? h_out.mc   : '0;
      bisector_a <= h_out.ok ? q_ba       : '0;
      bisector_b <= h_out.ok ? q_bb       : '0;
      bisector_c <= h_out.ok ? q_bc       : '0;
    end
  end

  // The parallel paths must stay in lockstep.
  a_paths_aligned: assert property (@(posedge clk) disable iff (rst)
    (hb_vld == ha_vld) && (ba_vld == ha_vld))
    else $error("parallel datapaths lost alignment");

  // Input backpressure comes only from a held result at the output.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !side_ready |-> (metric_valid && !metric_ready))
    else $error("input stalled without an output stall");

  // A passing triangle always has a nonzero perimeter.
  a_valid_perimeter: assert property (@(posedge clk) disable iff (rst)
    (metric_valid && valid_res) |-> (perimeter != '0))
    else $error("valid triangle with zero perimeter");

endmodule
